// File: sv/string_hash_slot_allocator_assert.svh
// Assertion helpers for the slot allocator.
`ifndef STRING_HASH_SLOT_ALLOCATOR_ASSERT_SVH
`define STRING_HASH_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SHSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("shsa: same-cycle check failed");

// Next-cycle implication.
`define SHSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("shsa: next-cycle check failed");

`endif

// File: sv/shsa_pkg.sv
package shsa_pkg;

	localparam int HASH_W = 32;
	localparam int CHAR_W = 7;

	localparam logic [HASH_W-1:0] RADIX      = 32'd31;
	localparam logic [HASH_W-1:0] GOLDEN_Q32 = 32'h9E3779B9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCALE,
		ST_HOME,
		ST_PROBE
	} state_t;

	typedef struct packed {
		logic take;   // character transfer this cycle
		logic mix;    // run the golden-ratio multiply
	} hash_ctl_t;

endpackage

// File: sv/shsa_if.sv
interface shsa_in_if;
	logic                           valid;
	logic                           ready;
	logic [shsa_pkg::CHAR_W-1:0]    key_char;
	logic                           last_char;

	modport source (output valid, output key_char, output last_char, input ready);
	modport sink   (input valid, input key_char, input last_char, output ready);
endinterface

interface shsa_out_if #(parameter int IDX_W = 6);
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] slot_index;
	logic             table_full;

	modport source (output valid, output slot_index, output table_full, input ready);
	modport sink   (input valid, input slot_index, input table_full, output ready);
endinterface

// File: sv/shsa_hash.sv
module shsa_hash (
	input  logic                          clk,
	input  logic                          arst_n,
	input  shsa_pkg::hash_ctl_t           ctl,
	input  logic [shsa_pkg::CHAR_W-1:0]   key_char,
	input  logic                          last_char,
	output logic [shsa_pkg::HASH_W-1:0]   frac
);

	logic [shsa_pkg::HASH_W-1:0] acc_q;
	logic [shsa_pkg::HASH_W-1:0] pow_q;
	logic [shsa_pkg::HASH_W-1:0] acc_s1;
	logic [shsa_pkg::HASH_W-1:0] frac_s2;
	logic [shsa_pkg::HASH_W-1:0] term;
	logic [shsa_pkg::HASH_W-1:0] acc_sum;
	logic [shsa_pkg::HASH_W-1:0] pow_next;
	logic [shsa_pkg::HASH_W-1:0] mixed;

	assign term     = pow_q * shsa_pkg::HASH_W'(key_char);
	assign acc_sum  = acc_q + term;
	assign pow_next = pow_q * shsa_pkg::RADIX;
	// Low word of the product is the 0.32 fraction for signed and unsigned alike.
	assign mixed    = acc_s1 * shsa_pkg::GOLDEN_Q32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pow_q <= shsa_pkg::HASH_W'(1);
		end else if (ctl.take) begin
			if (last_char) begin
				acc_q <= '0;
				pow_q <= shsa_pkg::HASH_W'(1);
			end else begin
				acc_q <= acc_sum;
				pow_q <= pow_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take && last_char) begin
			acc_s1 <= acc_sum;
		end
		if (ctl.mix) begin
			frac_s2 <= mixed;
		end
	end

	assign frac = frac_s2;

endmodule

// File: sv/shsa_cell.sv
module shsa_cell #(
	parameter int IDX_W = 6,
	parameter int IDX   = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             inject,
	input  logic [IDX_W-1:0] home,
	input  logic             tok_in,
	output logic             tok_out,
	output logic             grant
);

	logic used_q;
	logic tok_q;
	logic tok_here;

	assign tok_here = (inject && (home == IDX_W'(IDX))) || tok_in;
	assign grant    = tok_here && !used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			tok_q  <= 1'b0;
		end else begin
			used_q <= used_q || grant;
			// pass the probe on past an occupied slot
			tok_q  <= tok_here && used_q;
		end
	end

	assign tok_out = tok_q;

endmodule

// File: sv/string_hash_slot_allocator.sv
// String hash slot allocator. Key characters arrive on key_in in string order,
// last_char closing the key; each key yields one transfer on slot_out with the
// allocated slot, or table_full = 1 when every slot is taken. A character that
// is not the last is taken every cycle while the block is idle. The last
// character runs the steps accumulate, golden-ratio multiply, scale to SLOTS
// and probe at the home slot; the probe then passes each occupied slot in turn,
// since the probe token moves one cell of the slot ring per cycle. A full table
// answers at the home-slot step without probing. Characters of the next key are
// taken once the slot search of the key before ends, but its home-slot step
// holds while an earlier result still waits on slot_out, and that hold delays
// its result. Slots are freed only by reset, which clears every slot at once.
`include "string_hash_slot_allocator_assert.svh"

module string_hash_slot_allocator #(
	parameter int SLOTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	shsa_in_if.sink            key_in,
	shsa_out_if.source         slot_out
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int PRD_W = shsa_pkg::HASH_W + CNT_W;

	shsa_pkg::state_t    state_q, state_d;
	shsa_pkg::hash_ctl_t hash_ctl;

	logic [shsa_pkg::HASH_W-1:0] frac;
	logic [PRD_W-1:0]            scaled;
	logic [IDX_W-1:0]            home_q;
	logic [IDX_W-1:0]            probe_idx_q;
	logic [IDX_W-1:0]            cur_idx;
	logic [IDX_W-1:0]            next_idx;
	logic [CNT_W-1:0]            fill_q;
	logic [SLOTS-1:0]            tok;
	logic [SLOTS-1:0]            grant;
	logic                        any_grant;
	logic                        full;
	logic                        out_free;
	logic                        inject;
	logic                        load_full;
	logic                        out_valid_q;
	logic [IDX_W-1:0]            out_idx_q;
	logic                        out_full_q;

	assign full      = fill_q == CNT_W'(SLOTS);
	assign out_free  = !out_valid_q || slot_out.ready;
	assign any_grant = |grant;
	assign scaled    = PRD_W'(frac) * PRD_W'(SLOTS);
	assign cur_idx   = (state_q == shsa_pkg::ST_HOME) ? home_q : probe_idx_q;
	assign next_idx  = (cur_idx == IDX_W'(SLOTS - 1)) ? '0 : cur_idx + 1'b1;

	assign hash_ctl.take = key_in.valid && key_in.ready;
	assign hash_ctl.mix  = state_q == shsa_pkg::ST_MUL;

	shsa_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (hash_ctl),
		.key_char  (key_in.key_char),
		.last_char (key_in.last_char),
		.frac      (frac)
	);

	for (genvar i = 0; i < SLOTS; i++) begin : g_slot
		shsa_cell #(
			.IDX_W (IDX_W),
			.IDX   (i)
		) u_slot (
			.clk     (clk),
			.arst_n  (arst_n),
			.inject  (inject),
			.home    (home_q),
			.tok_in  (tok[(i + SLOTS - 1) % SLOTS]),
			.tok_out (tok[i]),
			.grant   (grant[i])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			shsa_pkg::ST_IDLE: begin
				if (hash_ctl.take && key_in.last_char) begin
					state_d = shsa_pkg::ST_MUL;
				end
			end
			shsa_pkg::ST_MUL:   state_d = shsa_pkg::ST_SCALE;
			shsa_pkg::ST_SCALE: state_d = shsa_pkg::ST_HOME;
			shsa_pkg::ST_HOME: begin
				if (out_free) begin
					state_d = (full || any_grant) ? shsa_pkg::ST_IDLE : shsa_pkg::ST_PROBE;
				end
			end
			shsa_pkg::ST_PROBE: begin
				if (any_grant) begin
					state_d = shsa_pkg::ST_IDLE;
				end
			end
			default: state_d = shsa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		key_in.ready = 1'b0;
		inject       = 1'b0;
		load_full    = 1'b0;
		case (state_q)
			shsa_pkg::ST_IDLE: key_in.ready = 1'b1;
			shsa_pkg::ST_HOME: begin
				inject    = out_free && !full;
				load_full = out_free && full;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= shsa_pkg::ST_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (any_grant) begin
				fill_q <= fill_q + 1'b1;
			end
			if (any_grant || load_full) begin
				out_valid_q <= 1'b1;
			end else if (slot_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == shsa_pkg::ST_SCALE) begin
			home_q <= scaled[shsa_pkg::HASH_W +: IDX_W];
		end
		// advance the probe index in step with the token
		probe_idx_q <= next_idx;
		if (any_grant) begin
			out_idx_q  <= cur_idx;
			out_full_q <= 1'b0;
		end else if (load_full) begin
			out_idx_q  <= '0;
			out_full_q <= 1'b1;
		end
	end

	assign slot_out.valid      = out_valid_q;
	assign slot_out.slot_index = out_idx_q;
	assign slot_out.table_full = out_full_q;

	`SHSA_ASSERT_NOW(a_one_grant, clk, arst_n, 1'b1, $onehot0(grant))
	`SHSA_ASSERT_NOW(a_no_grant_full, clk, arst_n, any_grant, !full)
	`SHSA_ASSERT_NOW(a_token_in_probe, clk, arst_n, |tok, state_q == shsa_pkg::ST_PROBE)
	`SHSA_ASSERT_NOW(a_probe_out_empty, clk, arst_n, state_q == shsa_pkg::ST_PROBE, !out_valid_q)

endmodule

// File: bench/tb.sv
module tb;

	localparam int SLOTS        = 64;
	localparam int IDX_W        = $clog2(SLOTS);
	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT  = 500_000;
	localparam int N_DIRECTED   = 21;

	typedef struct packed {
		logic [IDX_W-1:0] slot;
		logic             full;
	} alloc_t;

	typedef struct packed {
		logic [shsa_pkg::CHAR_W-1:0] ch;
		logic                        lst;
		bit                          typed;
		logic [IDX_W-1:0]            slot;
		logic                        full;
	} char_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	shsa_in_if                    key_if ();
	shsa_out_if #(.IDX_W(IDX_W))  slot_if ();

	string_hash_slot_allocator #(.SLOTS(SLOTS)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_in   (key_if),
		.slot_out (slot_if)
	);

	always #4 clk = ~clk;

	// Running hash state and occupancy, mirrored from the block's behavior.
	logic [shsa_pkg::HASH_W-1:0] hash_acc;
	logic [shsa_pkg::HASH_W-1:0] radix_pow;
	bit                          slot_taken [SLOTS];
	alloc_t                      alloc_expect_q [$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int items_sent     = 0;
	bit src_calm       = 1'b0;

	// Keys of zero hash land on slot 0 and probe upward from there.
	char_row_t directed_rows [N_DIRECTED] = '{
		'{7'h00, 1'b1, 1'b1, 6'd0, 1'b0},
		'{7'h00, 1'b1, 1'b1, 6'd1, 1'b0},
		'{7'h00, 1'b0, 1'b0, 6'd0, 1'b0},
		'{7'h00, 1'b1, 1'b1, 6'd2, 1'b0},
		'{7'h7F, 1'b1, 1'b0, 6'd0, 1'b0},
		'{7'h7F, 1'b0, 1'b0, 6'd0, 1'b0},
		'{7'h7F, 1'b0, 1'b0, 6'd0, 1'b0},
		'{7'h7F, 1'b0, 1'b0, 6'd0, 1'b0},
		'{7'h7F, 1'b0, 1'b0, 6'd0, 1'b0},
		'{7'h7F, 1'b0, 1'b0, 6'd0, 1'b0},
		'{7'h7F, 1'b0, 1'b0, 6'd0, 1'b0},
		'{7'h7F, 1'b0, 1'b0, 6'd0, 1'b0},
		'{7'h7F, 1'b1, 1'b0, 6'd0, 1'b0},
		'{7'h55, 1'b0, 1'b0, 6'd0, 1'b0},
		'{7'h2A, 1'b1, 1'b0, 6'd0, 1'b0},
		'{7'h01, 1'b0, 1'b0, 6'd0, 1'b0},
		'{7'h40, 1'b0, 1'b0, 6'd0, 1'b0},
		'{7'h7F, 1'b0, 1'b0, 6'd0, 1'b0},
		'{7'h20, 1'b1, 1'b0, 6'd0, 1'b0},
		'{7'h7F, 1'b0, 1'b0, 6'd0, 1'b0},
		'{7'h00, 1'b1, 1'b0, 6'd0, 1'b0}
	};

	function automatic int idle_len(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endtask

	// Fold one character into the hash; on the last one, place the key.
	task automatic hash_and_place(input logic [shsa_pkg::CHAR_W-1:0] ch, input logic lst,
		input bit typed, input alloc_t typed_res);
		logic [shsa_pkg::HASH_W-1:0] frac;
		int                          home;
		int                          idx;
		alloc_t                      res;
		hash_acc  = hash_acc + ch * radix_pow;
		radix_pow = radix_pow * shsa_pkg::RADIX;
		if (!lst)
			return;
		frac      = hash_acc * shsa_pkg::GOLDEN_Q32;
		home      = int'(frac[shsa_pkg::HASH_W-1 -: IDX_W]);
		hash_acc  = '0;
		radix_pow = 32'd1;
		res.full  = 1'b1;
		res.slot  = '0;
		for (int n = 0; n < SLOTS; n++) begin
			idx = (home + n) % SLOTS;
			if (!slot_taken[idx]) begin
				slot_taken[idx] = 1'b1;
				res.full        = 1'b0;
				res.slot        = idx[IDX_W-1:0];
				break;
			end
		end
		alloc_expect_q.insert(alloc_expect_q.size(), typed ? typed_res : res);
	endtask

	task automatic put_char(input logic [shsa_pkg::CHAR_W-1:0] ch, input logic lst,
		input bit typed, input alloc_t typed_res);
		int gap;
		key_if.valid     <= 1'b1;
		key_if.key_char  <= ch;
		key_if.last_char <= lst;
		do
			@(posedge clk);
		while (key_if.ready !== 1'b1);
		hash_and_place(ch, lst, typed, typed_res);
		items_sent++;
		if ($urandom_range(0, 59) == 0)
			src_calm = !src_calm;
		gap = idle_len(src_calm);
		if (gap > 0) begin
			key_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [shsa_pkg::CHAR_W-1:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return shsa_pkg::CHAR_W'($urandom_range(0, 127));
		if (r < 85)
			return shsa_pkg::CHAR_W'($urandom_range(97, 122));
		return r[0] ? 7'h7F : 7'h00;
	endfunction

	initial begin
		int     klen;
		int     r;
		alloc_t typed_res;
		key_if.valid     <= 1'b0;
		key_if.key_char  <= '0;
		key_if.last_char <= 1'b0;
		hash_acc  = '0;
		radix_pow = 32'd1;
		foreach (slot_taken[k])
			slot_taken[k] = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k]) begin
			typed_res.slot = directed_rows[k].slot;
			typed_res.full = directed_rows[k].full;
			put_char(directed_rows[k].ch, directed_rows[k].lst, directed_rows[k].typed,
				typed_res);
		end

		// Whole keys with random content; mostly short, a few long enough to wrap 31^i.
		typed_res = '0;
		while (items_sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				klen = $urandom_range(1, 6);
			else if (r < 95)
				klen = $urandom_range(7, 16);
			else
				klen = $urandom_range(17, 40);
			for (int j = 0; j < klen; j++)
				put_char(pick_char(), j == klen - 1, 1'b0, typed_res);
		end
		key_if.valid <= 1'b0;

		while (alloc_expect_q.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Result side: random stalls, with calm stretches of steady ready.
	initial begin
		int stall_left;
		bit calm;
		stall_left = 0;
		calm       = 1'b0;
		slot_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 79) == 0)
				calm = !calm;
			if (stall_left > 0) begin
				stall_left--;
				slot_if.ready <= 1'b0;
			end else begin
				stall_left = idle_len(calm);
				slot_if.ready <= (stall_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		alloc_t got;
		alloc_t want;
		if (arst_n === 1'b1 && slot_if.valid === 1'b1 && slot_if.ready === 1'b1) begin
			got.slot = slot_if.slot_index;
			got.full = slot_if.table_full;
			if (alloc_expect_q.size() == 0) begin
				note_failure($sformatf("unexpected transfer: slot_index %0d table_full %0b",
					got.slot, got.full));
			end else begin
				want = alloc_expect_q.pop_front();
				if (got.slot !== want.slot)
					note_failure($sformatf("slot_index: expected %0d, got %0d",
						want.slot, got.slot));
				if (got.full !== want.full)
					note_failure($sformatf("table_full: expected %0b, got %0b",
						want.full, got.full));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule
